// File: rtl/core/sink_window_token_ring_assert.svh
// Assertion macros shared by the sink window token ring RTL.
`ifndef SINK_WINDOW_TOKEN_RING_ASSERT_SVH
`define SINK_WINDOW_TOKEN_RING_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define SWTR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
		else $error("%m: assertion failed");

// Check that a condition never holds outside reset.
`define SWTR_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define SWTR_ASSERT(lbl, clk, rstn, prop)
`define SWTR_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: rtl/core/swtr_pkg.sv
// Shared types and constants of the sink window token ring.
`timescale 1ns / 1ps
`default_nettype none

package swtr_pkg;

	// Default sizes for the top level parameters
	localparam int SINK_MAX_DEF   = 16;
	localparam int WINDOW_MAX_DEF = 2048;
	localparam int TOKEN_BITS_DEF = 32;

	// Port field widths
	localparam int OPCODE_W   = 2;
	localparam int TOKEN_W    = 32;
	localparam int INDEX_W    = 12;
	localparam int COUNT_W    = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;
	localparam int SINK_CNT_W = 5;
	localparam int WIN_SIZE_W = 12;

	// Register reset values
	localparam int SINK_COUNT_RST  = 4;
	localparam int WINDOW_SIZE_RST = 2044;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SINK_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd1;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Memory actions decided for one transaction by the pointer logic
	typedef struct packed {
		logic sink_we;
		logic win_we;
		logic rd_sink;
		logic rd_win;
	} act_t;

endpackage

`default_nettype wire

// File: rtl/core/swtr_item_if.sv
// Input transaction channel: opcode, token and read position.
`timescale 1ns / 1ps
`default_nettype none

interface swtr_item_if;
	import swtr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OPCODE_W-1:0]       opcode;
	logic signed [TOKEN_W-1:0] token_in;
	logic [INDEX_W-1:0]        read_index;

	modport source (output valid, output opcode, output token_in, output read_index,
		input ready);
	modport sink (input valid, input opcode, input token_in, input read_index,
		output ready);
endinterface

`default_nettype wire

// File: rtl/core/swtr_result_if.sv
// Result transaction channel: token, stored count and beyond flag.
`timescale 1ns / 1ps
`default_nettype none

interface swtr_result_if;
	import swtr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [TOKEN_W-1:0] token_out;
	logic [COUNT_W-1:0]        stored_count;
	logic                      index_beyond;

	modport source (output valid, output token_out, output stored_count,
		output index_beyond, input ready);
	modport sink (input valid, input token_out, input stored_count,
		input index_beyond, output ready);
endinterface

`default_nettype wire

// File: rtl/core/swtr_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface swtr_cfg_if;
	import swtr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/swtr_mem.sv
// Single-port-write, registered-read token memory.
`timescale 1ns / 1ps
`default_nettype none

module swtr_mem #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, and read old contents on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/swtr_ctrl.sv
// Register file, fill counters and ring head, with per-transaction address decode.
`timescale 1ns / 1ps
`default_nettype none
`include "sink_window_token_ring_assert.svh"

module swtr_ctrl #(
	parameter int SINK_MAX   = swtr_pkg::SINK_MAX_DEF,
	parameter int WINDOW_MAX = swtr_pkg::WINDOW_MAX_DEF,
	localparam int SAW = (SINK_MAX > 1) ? $clog2(SINK_MAX) : 1,
	localparam int AW  = $clog2(WINDOW_MAX),
	localparam int FW  = $clog2(WINDOW_MAX + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [swtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swtr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                            op_fire,
	input  wire swtr_pkg::op_t                   opcode,
	input  wire logic [swtr_pkg::INDEX_W-1:0]    read_index,
	output swtr_pkg::act_t                       act,
	output logic [SAW-1:0]                       sink_waddr,
	output logic [SAW-1:0]                       sink_raddr,
	output logic [AW-1:0]                        win_waddr,
	output logic [FW-1:0]                        win_off,
	output logic [AW-1:0]                        ring_head,
	output logic [FW-1:0]                        win_size,
	output logic [swtr_pkg::COUNT_W-1:0]         count
);
	import swtr_pkg::*;

	localparam int SFW = $clog2(SINK_MAX + 1);
	localparam int CW  = (FW > INDEX_W) ? FW : INDEX_W;
	localparam int PW  = FW + 1;
	localparam int SINK_RST_EFF = (SINK_COUNT_RST > SINK_MAX) ? SINK_MAX : SINK_COUNT_RST;
	localparam int WIN_RST_EFF  = (WINDOW_SIZE_RST == 0) ? 1 :
		((WINDOW_SIZE_RST > WINDOW_MAX) ? WINDOW_MAX : WINDOW_SIZE_RST);

	logic [SFW-1:0] sinks_q;
	logic [FW-1:0]  win_q;
	logic [SFW-1:0] sink_fill_q;
	logic [FW-1:0]  window_fill_q;
	logic [AW-1:0]  head_q;

	logic [SFW-1:0] sinks_new;
	logic [FW-1:0]  win_new;
	logic [SFW-1:0] sink_fill_d;
	logic [FW-1:0]  window_fill_d;
	logic [AW-1:0]  head_d;
	logic           sink_room;
	logic           win_full;
	logic [PW-1:0]  psum;
	logic [PW-1:0]  pslot;
	logic [FW-1:0]  head_inc;
	logic [CW-1:0]  idx_w;
	logic [CW-1:0]  sf_w;
	logic [CW-1:0]  off;
	logic           hit_sink;
	logic           hit_win;

	// Clamp written register values to the sizes the storage supports
	always_comb begin
		if (int'(cfg_data[SINK_CNT_W-1:0]) > SINK_MAX) begin
			sinks_new = SFW'(SINK_MAX);
		end else begin
			sinks_new = SFW'(cfg_data[SINK_CNT_W-1:0]);
		end
		if (cfg_data[WIN_SIZE_W-1:0] == '0) begin
			win_new = FW'(1);
		end else if (int'(cfg_data[WIN_SIZE_W-1:0]) > WINDOW_MAX) begin
			win_new = FW'(WINDOW_MAX);
		end else begin
			win_new = FW'(cfg_data[WIN_SIZE_W-1:0]);
		end
	end

	// Push slot: one wrap of head plus fill around the window
	assign sink_room = sink_fill_q < sinks_q;
	assign win_full  = window_fill_q == win_q;
	assign psum      = PW'(head_q) + PW'(window_fill_q);
	assign pslot     = (psum >= PW'(win_q)) ? (psum - PW'(win_q)) : psum;
	assign head_inc  = FW'(head_q) + FW'(1);

	// Read position: sink prefix first, then offset into the window
	assign idx_w    = CW'(read_index);
	assign sf_w     = CW'(sink_fill_q);
	assign hit_sink = idx_w < sf_w;
	assign off      = idx_w - sf_w;
	assign hit_win  = !hit_sink && (off < CW'(window_fill_q));

	// Next pointer values for the transaction in decode
	always_comb begin
		sink_fill_d   = sink_fill_q;
		window_fill_d = window_fill_q;
		head_d        = head_q;
		unique case (opcode)
			OP_PUSH: begin
				if (sink_room) begin
					sink_fill_d = sink_fill_q + SFW'(1);
				end else if (!win_full) begin
					window_fill_d = window_fill_q + FW'(1);
				end else if (head_inc == win_q) begin
					head_d = '0;
				end else begin
					head_d = head_inc[AW-1:0];
				end
			end
			OP_CLEAR: begin
				sink_fill_d   = '0;
				window_fill_d = '0;
				head_d        = '0;
			end
			OP_READ, OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	assign act.sink_we = op_fire && (opcode == OP_PUSH) && sink_room;
	assign act.win_we  = op_fire && (opcode == OP_PUSH) && !sink_room;
	assign act.rd_sink = (opcode == OP_READ) && hit_sink;
	assign act.rd_win  = (opcode == OP_READ) && hit_win;

	assign sink_waddr = sink_fill_q[SAW-1:0];
	assign sink_raddr = read_index[SAW-1:0];
	assign win_waddr  = pslot[AW-1:0];
	assign win_off    = off[FW-1:0];
	assign ring_head  = head_q;
	assign win_size   = win_q;
	assign count      = COUNT_W'(CW'(sink_fill_d) + CW'(window_fill_d));

	// Hold registers and pointers; a register write also empties the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sinks_q       <= SFW'(SINK_RST_EFF);
			win_q         <= FW'(WIN_RST_EFF);
			sink_fill_q   <= '0;
			window_fill_q <= '0;
			head_q        <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_SINK_COUNT) begin
				sinks_q <= sinks_new;
			end
			if (cfg_index == REG_WINDOW_SIZE) begin
				win_q <= win_new;
			end
			sink_fill_q   <= '0;
			window_fill_q <= '0;
			head_q        <= '0;
		end else if (op_fire) begin
			sink_fill_q   <= sink_fill_d;
			window_fill_q <= window_fill_d;
			head_q        <= head_d;
		end
	end

	`SWTR_ASSERT(a_fill_fits, clk, arst_n, window_fill_q <= win_q)
	`SWTR_ASSERT(a_head_fits, clk, arst_n, FW'(head_q) < win_q)
	`SWTR_ASSERT(a_sinks_fit, clk, arst_n, sink_fill_q <= sinks_q)
	`SWTR_ASSERT(a_sinks_first, clk, arst_n, (window_fill_q != '0) |-> (sink_fill_q == sinks_q))

endmodule

`default_nettype wire

// File: rtl/core/sink_window_token_ring.sv
// Top level of the sink window token ring: pipeline, memories and channels.
`timescale 1ns / 1ps
`default_nettype none
`include "sink_window_token_ring_assert.svh"

// Token history store: the first sink_count pushes land in a fixed sink prefix,
// later pushes go to a ring of window_size entries that overwrites its oldest
// entry once full. A read returns the token at a logical position (sinks first,
// then window oldest to newest), the stored count and a beyond-count flag; a
// clear or any register write empties the store. Every transaction gives one
// result. The block takes one transaction per cycle while results are taken and
// presents each result from the stage 3 registers: pointer decode in stage 1 is
// latched into stage 2, where the window slot wraps and the token memories are
// read into their output registers. A held result stalls the stages behind it
// only as they fill up.
// Both token memories start with undefined contents and need no clearing pass;
// reads never reach an entry that has not been pushed.
module sink_window_token_ring #(
	parameter int SINK_MAX   = swtr_pkg::SINK_MAX_DEF,
	parameter int WINDOW_MAX = swtr_pkg::WINDOW_MAX_DEF,
	parameter int TOKEN_BITS = swtr_pkg::TOKEN_BITS_DEF
) (
	input wire logic      clk,
	input wire logic      arst_n,
	swtr_item_if.sink     item,
	swtr_result_if.source result,
	swtr_cfg_if.sink      cfg
);
	import swtr_pkg::*;

	localparam int SAW = (SINK_MAX > 1) ? $clog2(SINK_MAX) : 1;
	localparam int AW  = $clog2(WINDOW_MAX);
	localparam int FW  = $clog2(WINDOW_MAX + 1);
	localparam int PW  = FW + 1;

	// Stage enables: a stage moves when the one after it is empty or moving
	logic en1;
	logic en2;
	logic en3;

	// Stage 1: accepted transaction
	logic                  valid_s1;
	op_t                   opcode_s1;
	logic [TOKEN_BITS-1:0] token_s1;
	logic [INDEX_W-1:0]    index_s1;

	// Stage 2: resolved read target
	logic               valid_s2;
	logic               rd_sink_s2;
	logic               rd_win_s2;
	logic               beyond_s2;
	logic [SAW-1:0]     sink_raddr_s2;
	logic [FW-1:0]      off_s2;
	logic [AW-1:0]      head_s2;
	logic [COUNT_W-1:0] count_s2;

	// Stage 3: result, with token from the memory read registers
	logic               valid_s3;
	logic               rd_sink_s3;
	logic               rd_win_s3;
	logic               beyond_s3;
	logic [COUNT_W-1:0] count_s3;

	act_t                  act;
	logic [SAW-1:0]        sink_waddr;
	logic [SAW-1:0]        sink_raddr;
	logic [AW-1:0]         win_waddr;
	logic [FW-1:0]         win_off;
	logic [AW-1:0]         ring_head;
	logic [FW-1:0]         win_size;
	logic [COUNT_W-1:0]    count;
	logic [PW-1:0]         rsum;
	logic [PW-1:0]         rslot;
	logic                  mem_re;
	logic [TOKEN_BITS-1:0] sink_rdata;
	logic [TOKEN_BITS-1:0] win_rdata;

	assign en3 = !valid_s3 || result.ready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign item.ready = en1;
	assign cfg.ready  = 1'b1;

	swtr_ctrl #(
		.SINK_MAX   (SINK_MAX),
		.WINDOW_MAX (WINDOW_MAX)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.op_fire    (valid_s1 && en2),
		.opcode     (opcode_s1),
		.read_index (index_s1),
		.act        (act),
		.sink_waddr (sink_waddr),
		.sink_raddr (sink_raddr),
		.win_waddr  (win_waddr),
		.win_off    (win_off),
		.ring_head  (ring_head),
		.win_size   (win_size),
		.count      (count)
	);

	// Stage 1: capture the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && item.valid) begin
			opcode_s1 <= op_t'(item.opcode);
			token_s1  <= item.token_in[TOKEN_BITS-1:0];
			index_s1  <= item.read_index;
		end
	end

	// Stage 2: latch the read target and the count after this transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			rd_sink_s2    <= act.rd_sink;
			rd_win_s2     <= act.rd_win;
			beyond_s2     <= (opcode_s1 == OP_READ) && !act.rd_sink && !act.rd_win;
			sink_raddr_s2 <= sink_raddr;
			off_s2        <= win_off;
			head_s2       <= ring_head;
			count_s2      <= count;
		end
	end

	// Wrap the window read slot once around the ring
	assign rsum   = PW'(head_s2) + PW'(off_s2);
	assign rslot  = (rsum >= PW'(win_size)) ? (rsum - PW'(win_size)) : rsum;
	assign mem_re = en3 && valid_s2;

	swtr_mem #(
		.DEPTH  (SINK_MAX),
		.WIDTH  (TOKEN_BITS),
		.ADDR_W (SAW)
	) u_sink_mem (
		.clk   (clk),
		.we    (act.sink_we),
		.waddr (sink_waddr),
		.wdata (token_s1),
		.re    (mem_re),
		.raddr (sink_raddr_s2),
		.rdata (sink_rdata)
	);

	swtr_mem #(
		.DEPTH  (WINDOW_MAX),
		.WIDTH  (TOKEN_BITS),
		.ADDR_W (AW)
	) u_win_mem (
		.clk   (clk),
		.we    (act.win_we),
		.waddr (win_waddr),
		.wdata (token_s1),
		.re    (mem_re),
		.raddr (rslot[AW-1:0]),
		.rdata (win_rdata)
	);

	// Stage 3: hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_sink_s3 <= rd_sink_s2;
			rd_win_s3  <= rd_win_s2;
			beyond_s3  <= beyond_s2;
			count_s3   <= count_s2;
		end
	end

	// Select and sign-extend the token read
	always_comb begin
		priority if (rd_sink_s3) begin
			result.token_out = TOKEN_W'($signed(sink_rdata));
		end else if (rd_win_s3) begin
			result.token_out = TOKEN_W'($signed(win_rdata));
		end else begin
			result.token_out = '0;
		end
	end

	assign result.valid        = valid_s3;
	assign result.stored_count = count_s3;
	assign result.index_beyond = beyond_s3;

	`SWTR_NEVER(a_one_target, clk, arst_n, valid_s3 && rd_sink_s3 && rd_win_s3)
	`SWTR_NEVER(a_beyond_hit, clk, arst_n, valid_s3 && beyond_s3 && (rd_sink_s3 || rd_win_s3))
	`SWTR_NEVER(a_write_both, clk, arst_n, act.sink_we && act.win_we)
	`SWTR_ASSERT(a_accept_lands, clk, arst_n, (item.valid && item.ready) |=> valid_s1)

endmodule

`default_nettype wire
